>>> hw/rtl/smat_pkg.sv
`timescale 1ns / 1ps

package smat_pkg;

  // Window depth in samples and the width that each sample is reduced to.
  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;

  localparam int CHANNELS  = 6;
  localparam int CH_W      = 3;
  localparam int FIELD_W   = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_RESET = 50;

  localparam int COUNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W     = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int DIFF_W    = SAMPLE_WIDTH + 1;
  localparam int RAM_DEPTH = MAX_WINDOW * CHANNELS;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int CMP_W     = (CFG_W > COUNT_W) ? CFG_W : COUNT_W;
  localparam int SAT_EXT_W = DIFF_W + FIELD_W;

  // Command carried in the input tuser.
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [COUNT_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                           busy;
    logic                           done;
    logic signed [SAMPLE_WIDTH-1:0] quotient;
  } div_rsp_t;

  // Takes the low SAMPLE_WIDTH bits of a sample as a signed value; bits above the
  // field are zero.
  function automatic logic signed [SAMPLE_WIDTH-1:0] widen(input logic [FIELD_W-1:0] v);
    logic [SAMPLE_WIDTH+FIELD_W-1:0] ext;
    ext = {{SAMPLE_WIDTH{1'b0}}, v};
    return $signed(ext[SAMPLE_WIDTH-1:0]);
  endfunction

  // Clamps a difference to the signed range of an output field.
  function automatic logic [FIELD_W-1:0] sat_out(input logic signed [DIFF_W-1:0] d);
    logic signed [SAT_EXT_W-1:0] ext;
    logic signed [SAT_EXT_W-1:0] hi;
    logic signed [SAT_EXT_W-1:0] lo;
    ext = SAT_EXT_W'(d);
    hi  = SAT_EXT_W'($signed({1'b0, {(FIELD_W-1){1'b1}}}));
    lo  = SAT_EXT_W'($signed({1'b1, {(FIELD_W-1){1'b0}}}));
    if (ext > hi) begin
      return hi[FIELD_W-1:0];
    end else if (ext < lo) begin
      return lo[FIELD_W-1:0];
    end
    return ext[FIELD_W-1:0];
  endfunction

endpackage

>>> hw/rtl/smat_ram.sv
`timescale 1ns / 1ps

module smat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/smat_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, truncating toward zero.
module smat_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smat_pkg::div_req_t  req_i,
  output smat_pkg::div_rsp_t  rsp_o
);

  localparam int STEP_W = $clog2(smat_pkg::SUM_W + 1);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [STEP_W-1:0]                cnt_q, cnt_d;
  logic                             neg_q, neg_d;
  logic [smat_pkg::SUM_W-1:0]       dq_q, dq_d;
  logic [smat_pkg::COUNT_W-1:0]     rem_q, rem_d;
  logic [smat_pkg::COUNT_W-1:0]     dvs_q, dvs_d;

  logic [smat_pkg::COUNT_W:0]       shifted;
  logic [smat_pkg::COUNT_W:0]       trial;
  logic                             fits;
  logic [smat_pkg::SUM_W-1:0]       magnitude;
  logic [smat_pkg::SUM_W-1:0]       quot_full;

  always_comb begin
    shifted   = {rem_q, dq_q[smat_pkg::SUM_W-1]};
    trial     = shifted - {1'b0, dvs_q};
    fits      = shifted >= {1'b0, dvs_q};
    magnitude = req_i.dividend[smat_pkg::SUM_W-1] ? (~req_i.dividend + 1'b1)
                                                  : req_i.dividend;
    quot_full = neg_q ? (~dq_q + 1'b1) : dq_q;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;

    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(smat_pkg::SUM_W);
      neg_d  = req_i.dividend[smat_pkg::SUM_W-1];
      dq_d   = magnitude;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? trial[smat_pkg::COUNT_W-1:0] : shifted[smat_pkg::COUNT_W-1:0];
      dq_d  = {dq_q[smat_pkg::SUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = $signed(quot_full[smat_pkg::SAMPLE_WIDTH-1:0]);

endmodule

>>> hw/rtl/six_axis_moving_average_tare_top.sv
`timescale 1ns / 1ps

// Channel      Direction  Handshake             Payload
// s_axis       in         tvalid / tready       tdata: six samples, tuser: command
// m_axis       out        tvalid / tready       tdata: six results, tuser: empty flag
// cfg          in         cfg_valid / cfg_ready cfg_data: window size
//
// A sample item is accepted and then written to the RAM one channel at a time; when the
// oldest sample is evicted first, each channel gets a RAM read and a subtract before the
// writes. A read item runs the one-bit-per-cycle divider, shared by all channels, once per
// channel; an empty read goes straight to S_OUT. Reset clears sums, count and offsets
// and arms the tare; the sample RAM needs no clearing. A finished result waits in S_OUT,
// with s_axis_tready_o low, until the output register is free.
module six_axis_moving_average_tare_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z, from the lowest bit up
  input  logic [191:0] s_axis_tdata_i,
  // command
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_force_x, out_force_y, out_force_z, out_torque_x, out_torque_y,
  // out_torque_z, from the lowest bit up
  output logic [191:0] m_axis_tdata_o,
  // window_empty
  output logic [0:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [6:0]   cfg_data_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EV_RD    = 3'd1;
  localparam logic [2:0] S_EV_SUB   = 3'd2;
  localparam logic [2:0] S_WRITE    = 3'd3;
  localparam logic [2:0] S_RD_START = 3'd4;
  localparam logic [2:0] S_RD_WAIT  = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  localparam logic [smat_pkg::CH_W-1:0] LAST_CH = smat_pkg::CH_W'(smat_pkg::CHANNELS - 1);

  logic [2:0]                          state_q, state_d;
  logic [smat_pkg::CH_W-1:0]           ch_q, ch_d;
  logic [smat_pkg::COUNT_W-1:0]        count_q, count_d;
  logic [smat_pkg::SLOT_W-1:0]         wslot_q, wslot_d;
  logic                                tare_q, tare_d;
  logic [smat_pkg::CFG_W-1:0]          wsize_q, wsize_d;
  logic signed [smat_pkg::SUM_W-1:0]   sums_q [smat_pkg::CHANNELS];
  logic signed [smat_pkg::SUM_W-1:0]   sums_d [smat_pkg::CHANNELS];
  logic signed [smat_pkg::SAMPLE_WIDTH-1:0] offs_q [smat_pkg::CHANNELS];
  logic signed [smat_pkg::SAMPLE_WIDTH-1:0] offs_d [smat_pkg::CHANNELS];
  logic [smat_pkg::FIELD_W-1:0]        in_q [smat_pkg::CHANNELS];
  logic [smat_pkg::FIELD_W-1:0]        in_d [smat_pkg::CHANNELS];
  logic [smat_pkg::FIELD_W-1:0]        res_q [smat_pkg::CHANNELS];
  logic [smat_pkg::FIELD_W-1:0]        res_d [smat_pkg::CHANNELS];
  logic                                res_empty_q, res_empty_d;
  logic [smat_pkg::FIELD_W-1:0]        out_q [smat_pkg::CHANNELS];
  logic [smat_pkg::FIELD_W-1:0]        out_d [smat_pkg::CHANNELS];
  logic                                out_empty_q, out_empty_d;
  logic                                m_valid_q, m_valid_d;

  logic                                in_fire;
  logic [smat_pkg::CMP_W-1:0]          eff_win;
  logic                                need_evict;
  logic [smat_pkg::COUNT_W:0]          oldest_raw;
  logic [smat_pkg::COUNT_W:0]          oldest_wrap;
  logic [smat_pkg::SLOT_W-1:0]         oldest;
  logic [smat_pkg::SLOT_W-1:0]         slot_sel;
  logic [smat_pkg::ADDR_W-1:0]         slot_addr;
  logic signed [smat_pkg::SAMPLE_WIDTH-1:0] new_sample;
  logic signed [smat_pkg::SAMPLE_WIDTH-1:0] old_sample;
  logic [smat_pkg::SAMPLE_WIDTH-1:0]   ram_rdata;
  logic                                ram_we;
  logic signed [smat_pkg::SUM_W-1:0]   addend;
  logic signed [smat_pkg::SUM_W-1:0]   sum_upd;
  logic signed [smat_pkg::SAMPLE_WIDTH-1:0] mean;
  logic signed [smat_pkg::SAMPLE_WIDTH-1:0] off_sel;
  logic signed [smat_pkg::DIFF_W-1:0]  diff;
  smat_pkg::div_req_t                  div_req;
  smat_pkg::div_rsp_t                  div_rsp;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;

  // Effective window: zero acts as one, anything past the store depth is clipped.
  always_comb begin
    if (wsize_q == '0) begin
      eff_win = smat_pkg::CMP_W'(1);
    end else if (smat_pkg::CMP_W'(wsize_q) > smat_pkg::CMP_W'(smat_pkg::MAX_WINDOW)) begin
      eff_win = smat_pkg::CMP_W'(smat_pkg::MAX_WINDOW);
    end else begin
      eff_win = smat_pkg::CMP_W'(wsize_q);
    end
    need_evict = (smat_pkg::CMP_W'(count_q) >= eff_win) && (count_q != '0);
  end

  // The oldest held slot sits count samples behind the write slot, modulo the depth.
  always_comb begin
    oldest_raw  = {1'b0, smat_pkg::COUNT_W'(wslot_q)} - {1'b0, count_q};
    oldest_wrap = oldest_raw + (smat_pkg::COUNT_W + 1)'(smat_pkg::MAX_WINDOW);
    oldest      = oldest_raw[smat_pkg::COUNT_W] ? oldest_wrap[smat_pkg::SLOT_W-1:0]
                                                : oldest_raw[smat_pkg::SLOT_W-1:0];
    slot_sel    = (state_q == S_WRITE) ? wslot_q : oldest;
    slot_addr   = smat_pkg::ADDR_W'(slot_sel) * smat_pkg::ADDR_W'(smat_pkg::CHANNELS)
                + smat_pkg::ADDR_W'(ch_q);
  end

  assign new_sample = smat_pkg::widen(in_q[ch_q]);
  assign old_sample = $signed(ram_rdata);
  assign ram_we     = (state_q == S_WRITE);

  smat_ram #(
    .WIDTH (smat_pkg::SAMPLE_WIDTH),
    .DEPTH (smat_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_addr),
    .wdata_i (new_sample),
    .raddr_i (slot_addr),
    .rdata_o (ram_rdata)
  );

  // One adder serves both the eviction subtract and the new-sample add.
  always_comb begin
    addend  = (state_q == S_EV_SUB) ? smat_pkg::SUM_W'(old_sample)
                                    : smat_pkg::SUM_W'(new_sample);
    sum_upd = (state_q == S_EV_SUB) ? (sums_q[ch_q] - addend) : (sums_q[ch_q] + addend);
  end

  assign div_req.start    = (state_q == S_RD_START);
  assign div_req.dividend = sums_q[ch_q];
  assign div_req.divisor  = count_q;

  smat_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // While the tare is pending the offset is the mean itself, so the result is zero.
  always_comb begin
    mean    = div_rsp.quotient;
    off_sel = tare_q ? mean : offs_q[ch_q];
    diff    = smat_pkg::DIFF_W'(mean) - smat_pkg::DIFF_W'(off_sel);
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    count_d     = count_q;
    wslot_d     = wslot_q;
    tare_d      = tare_q;
    wsize_d     = wsize_q;
    sums_d      = sums_q;
    offs_d      = offs_q;
    in_d        = in_q;
    res_d       = res_q;
    res_empty_d = res_empty_q;
    out_d       = out_q;
    out_empty_d = out_empty_q;
    m_valid_d   = m_valid_q;

    if (cfg_valid_i && cfg_ready_o) begin
      wsize_d = cfg_data_i;
    end

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          for (int c = 0; c < smat_pkg::CHANNELS; c++) begin
            in_d[c] = s_axis_tdata_i[c*smat_pkg::FIELD_W +: smat_pkg::FIELD_W];
          end
          ch_d = '0;
          if (s_axis_tuser_i[0] == smat_pkg::CMD_READ) begin
            if (count_q == '0) begin
              for (int c = 0; c < smat_pkg::CHANNELS; c++) begin
                res_d[c] = '0;
              end
              res_empty_d = 1'b1;
              state_d     = S_OUT;
            end else begin
              res_empty_d = 1'b0;
              state_d     = S_RD_START;
            end
          end else begin
            state_d = need_evict ? S_EV_RD : S_WRITE;
          end
        end
      end
      S_EV_RD: begin
        state_d = S_EV_SUB;
      end
      S_EV_SUB: begin
        sums_d[ch_q] = sum_upd;
        if (ch_q == LAST_CH) begin
          ch_d    = '0;
          count_d = count_q - 1'b1;
          state_d = S_WRITE;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_EV_RD;
        end
      end
      S_WRITE: begin
        sums_d[ch_q] = sum_upd;
        if (ch_q == LAST_CH) begin
          ch_d    = '0;
          count_d = count_q + 1'b1;
          wslot_d = (wslot_q == smat_pkg::SLOT_W'(smat_pkg::MAX_WINDOW - 1)) ? '0
                                                                              : wslot_q + 1'b1;
          state_d = S_IDLE;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      S_RD_START: begin
        state_d = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (div_rsp.done) begin
          if (tare_q) begin
            offs_d[ch_q] = mean;
          end
          res_d[ch_q] = smat_pkg::sat_out(diff);
          if (ch_q == LAST_CH) begin
            ch_d    = '0;
            tare_d  = 1'b0;
            state_d = S_OUT;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = S_RD_START;
          end
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_empty_d = res_empty_q;
          m_valid_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ch_q      <= '0;
      count_q   <= '0;
      wslot_q   <= '0;
      tare_q    <= 1'b1;
      wsize_q   <= smat_pkg::CFG_W'(smat_pkg::CFG_RESET);
      m_valid_q <= 1'b0;
      for (int c = 0; c < smat_pkg::CHANNELS; c++) begin
        sums_q[c] <= '0;
        offs_q[c] <= '0;
      end
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      count_q   <= count_d;
      wslot_q   <= wslot_d;
      tare_q    <= tare_d;
      wsize_q   <= wsize_d;
      m_valid_q <= m_valid_d;
      sums_q    <= sums_d;
      offs_q    <= offs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    res_q       <= res_d;
    res_empty_q <= res_empty_d;
    out_q       <= out_d;
    out_empty_q <= out_empty_d;
  end

  always_comb begin
    for (int c = 0; c < smat_pkg::CHANNELS; c++) begin
      m_axis_tdata_o[c*smat_pkg::FIELD_W +: smat_pkg::FIELD_W] = out_q[c];
    end
  end

  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tuser_o[0] = out_empty_q;

  // The window never holds more samples than the store has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= smat_pkg::COUNT_W'(smat_pkg::MAX_WINDOW))
    else $error("sample count exceeds store depth");

  // The divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Once an item is taken, the block stays busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("input accepted back to back");

  // An empty-window result carries all-zero channel values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("empty result with nonzero data");

endmodule
